[src/wfa_pkg.sv]
package wfa_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 16;
    localparam int ARENA_RESET  = 4096;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W = 17;

    typedef struct packed {
        logic        used;
        logic [15:0] bytes;
    } entry_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_FIT       = 3'd1,
        ST_TABLE_FULL   = 3'd2,
        ST_UNKNOWN      = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

endpackage

[src/wfa_if.sv]
interface wfa_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] request_bytes;
    logic [15:0] release_offset;

    modport source (output valid, output opcode, output request_bytes,
                    output release_offset, input ready);
    modport sink   (input valid, input opcode, input request_bytes,
                    input release_offset, output ready);
endinterface

interface wfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] payload_offset;

    modport source (output valid, output status, output payload_offset, input ready);
    modport sink   (input valid, input status, input payload_offset, output ready);
endinterface

[src/worst_fit_arena_allocator.sv]
// Worst-fit arena allocator.
// Requests arrive on the req channel (opcode, request_bytes, release_offset);
// each that a cfg_we write does not cut off gives exactly one transfer on the
// rsp channel (status, payload_offset). The block table lives in a single
// memory with a registered read. A request first scans the table, then may
// shift entries up by one on a split or down by one or two on a merge, then
// writes one or two entries when it succeeds. One request is worked on at a
// time. After reset, and after each write of arena_bytes through
// cfg_we/cfg_wdata, the table is set to one free block; reset loads 4096 bytes.
// A finished result sits in an output register until the receiver takes it;
// a new request is accepted meanwhile, but its own result waits while the
// previous one is still held.
module worst_fit_arena_allocator (
    input  logic             clk,
    input  logic             rst_n,
    wfa_req_if.sink          req,
    wfa_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata
);

    localparam int IW = wfa_pkg::IDX_W;
    localparam int CW = wfa_pkg::CNT_W;
    localparam int OW = wfa_pkg::OFF_W;
    localparam logic [15:0] HDR16 = 16'(wfa_pkg::HEADER_BYTES);
    localparam logic [OW-1:0] HDR_O = OW'(wfa_pkg::HEADER_BYTES);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_WR_A, S_WR_B, S_DONE
    } state_t;

    state_t              state_reg;
    logic [15:0]         arena_reg;
    logic [CW-1:0]       total_reg;

    logic                op_reg;
    logic [15:0]         size_reg;
    logic [15:0]         target_reg;

    logic [CW-1:0]       rd_idx_reg;
    logic                pv_reg;
    logic [IW-1:0]       pidx_reg;
    logic [OW-1:0]       run_off_reg;

    logic [15:0]         sbest_v_reg;
    logic [IW-1:0]       sbest_idx_reg;
    logic [OW-1:0]       sbest_off_reg;
    logic [15:0]         wbest_v_reg;
    logic [IW-1:0]       wbest_idx_reg;
    logic [OW-1:0]       wbest_off_reg;

    logic                found_reg;
    logic                have_next_reg;
    logic [IW-1:0]       fidx_reg;
    wfa_pkg::entry_t     cur_reg;
    wfa_pkg::entry_t     prev_reg;
    wfa_pkg::entry_t     next_reg;

    logic                split_reg;
    logic                up_reg;
    logic [1:0]          k_reg;
    logic [CW-1:0]       sh_cnt_reg;
    logic [IW-1:0]       sh_src_reg;
    logic                wpv_reg;
    logic [IW-1:0]       wdst_reg;

    logic [IW-1:0]       wa_reg;
    wfa_pkg::entry_t     wa_data_reg;
    logic [IW-1:0]       wb_reg;
    wfa_pkg::entry_t     wb_data_reg;

    wfa_pkg::status_t    res_status_reg;
    logic [15:0]         res_off_reg;

    logic                out_valid_reg;
    logic [2:0]          out_status_reg;
    logic [15:0]         out_off_reg;

    // Memory ports.
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    wfa_pkg::entry_t     mem_wdata;
    logic [IW-1:0]       mem_raddr;
    wfa_pkg::entry_t     mem_rdata;

    logic                scan_issue;
    logic                sh_issue;
    logic [OW-1:0]       need17;
    logic                split_ok;
    logic                whole_ok;
    logic                match_now;

    wfa_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign scan_issue = (state_reg == S_SCAN) && (rd_idx_reg < total_reg) && !found_reg;
    assign sh_issue   = (state_reg == S_SHIFT) && (sh_cnt_reg != '0);
    assign need17     = {1'b0, size_reg} + HDR_O;
    assign split_ok   = !mem_rdata.used && ({1'b0, mem_rdata.bytes} >= need17)
                        && (mem_rdata.bytes > sbest_v_reg);
    assign whole_ok   = !mem_rdata.used && (mem_rdata.bytes >= size_reg)
                        && ({1'b0, mem_rdata.bytes} < need17)
                        && (mem_rdata.bytes > wbest_v_reg);
    assign match_now  = pv_reg && !found_reg && (run_off_reg == {1'b0, target_reg});

    always_comb
    begin
        mem_raddr = scan_issue ? rd_idx_reg[IW-1:0] : sh_src_reg;
        mem_we    = 1'b0;
        mem_waddr = wa_reg;
        mem_wdata = wa_data_reg;
        case (state_reg)
            S_INIT:
            begin
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata.used  = 1'b0;
                mem_wdata.bytes = (arena_reg > HDR16) ? (arena_reg - HDR16) : 16'd0;
            end
            S_SHIFT:
            begin
                mem_we    = wpv_reg;
                mem_waddr = wdst_reg;
                mem_wdata = mem_rdata;
            end
            S_WR_A:
            begin
                mem_we = 1'b1;
            end
            S_WR_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = wb_reg;
                mem_wdata = wb_data_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.payload_offset = out_off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            arena_reg     <= 16'(wfa_pkg::ARENA_RESET);
            total_reg     <= CW'(1);
            pv_reg        <= 1'b0;
            wpv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // In S_DONE the output register is reloaded instead of cleared, unless cfg_we is high.
            if (rsp.ready && out_valid_reg && (cfg_we || state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                arena_reg <= cfg_wdata;
                state_reg <= S_INIT;
            end
            else
            begin
                case (state_reg)
                    S_INIT:
                    begin
                        total_reg <= CW'(1);
                        state_reg <= S_IDLE;
                    end

                    S_IDLE:
                    begin
                        if (req.valid)
                        begin
                            op_reg        <= req.opcode;
                            size_reg      <= req.request_bytes;
                            target_reg    <= req.release_offset;
                            rd_idx_reg    <= '0;
                            pv_reg        <= 1'b0;
                            run_off_reg   <= HDR_O;
                            sbest_v_reg   <= '0;
                            wbest_v_reg   <= '0;
                            found_reg     <= 1'b0;
                            have_next_reg <= 1'b0;
                            state_reg     <= S_SCAN;
                        end
                    end

                    S_SCAN:
                    begin
                        pv_reg   <= scan_issue;
                        pidx_reg <= rd_idx_reg[IW-1:0];
                        if (scan_issue)
                        begin
                            rd_idx_reg <= rd_idx_reg + CW'(1);
                        end
                        if (pv_reg)
                        begin
                            run_off_reg <= run_off_reg + {1'b0, mem_rdata.bytes} + HDR_O;
                            if (split_ok)
                            begin
                                sbest_v_reg   <= mem_rdata.bytes;
                                sbest_idx_reg <= pidx_reg;
                                sbest_off_reg <= run_off_reg;
                            end
                            if (whole_ok)
                            begin
                                wbest_v_reg   <= mem_rdata.bytes;
                                wbest_idx_reg <= pidx_reg;
                                wbest_off_reg <= run_off_reg;
                            end
                            if (found_reg)
                            begin
                                next_reg      <= mem_rdata;
                                have_next_reg <= 1'b1;
                            end
                            else if (match_now && op_reg == wfa_pkg::OP_FREE)
                            begin
                                found_reg <= 1'b1;
                                fidx_reg  <= pidx_reg;
                                cur_reg   <= mem_rdata;
                            end
                            else
                            begin
                                prev_reg <= mem_rdata;
                            end
                        end
                        if (!pv_reg && !scan_issue)
                        begin
                            state_reg <= S_DECIDE;
                        end
                    end

                    S_DECIDE:
                    begin
                        wpv_reg <= 1'b0;
                        if (op_reg == wfa_pkg::OP_ALLOC)
                        begin
                            if (size_reg > arena_reg)
                            begin
                                res_status_reg <= wfa_pkg::ST_NO_FIT;
                                res_off_reg    <= '0;
                                state_reg      <= S_DONE;
                            end
                            else if (sbest_v_reg != '0)
                            begin
                                if (total_reg == CW'(wfa_pkg::MAX_BLOCKS))
                                begin
                                    res_status_reg <= wfa_pkg::ST_TABLE_FULL;
                                    res_off_reg    <= '0;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    res_status_reg    <= wfa_pkg::ST_OK;
                                    res_off_reg       <= sbest_off_reg[15:0];
                                    split_reg         <= 1'b1;
                                    up_reg            <= 1'b1;
                                    sh_src_reg        <= IW'(total_reg - CW'(1));
                                    sh_cnt_reg        <= total_reg - CW'(1)
                                                         - CW'(sbest_idx_reg);
                                    wa_reg            <= sbest_idx_reg + IW'(1);
                                    wa_data_reg.used  <= 1'b0;
                                    wa_data_reg.bytes <= sbest_v_reg - size_reg - HDR16;
                                    wb_reg            <= sbest_idx_reg;
                                    wb_data_reg.used  <= 1'b1;
                                    wb_data_reg.bytes <= size_reg;
                                    total_reg         <= total_reg + CW'(1);
                                    state_reg         <= S_SHIFT;
                                end
                            end
                            else if (wbest_v_reg != '0)
                            begin
                                res_status_reg    <= wfa_pkg::ST_OK;
                                res_off_reg       <= wbest_off_reg[15:0];
                                wb_reg            <= wbest_idx_reg;
                                wb_data_reg.used  <= 1'b1;
                                wb_data_reg.bytes <= wbest_v_reg;
                                state_reg         <= S_WR_B;
                            end
                            else
                            begin
                                res_status_reg <= wfa_pkg::ST_NO_FIT;
                                res_off_reg    <= '0;
                                state_reg      <= S_DONE;
                            end
                        end
                        else
                        begin
                            if (!found_reg)
                            begin
                                res_status_reg <= wfa_pkg::ST_UNKNOWN;
                                res_off_reg    <= '0;
                                state_reg      <= S_DONE;
                            end
                            else if (!cur_reg.used)
                            begin
                                res_status_reg <= wfa_pkg::ST_ALREADY_FREE;
                                res_off_reg    <= '0;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin : free_merge
                                logic          nf;
                                logic          pf;
                                logic [1:0]    k;
                                logic [15:0]   merged;
                                logic [IW-1:0] tgt;
                                nf     = have_next_reg && !next_reg.used;
                                pf     = (fidx_reg != '0) && !prev_reg.used;
                                k      = {1'b0, nf} + {1'b0, pf};
                                merged = cur_reg.bytes
                                         + (nf ? (next_reg.bytes + HDR16) : 16'd0);
                                tgt    = pf ? (fidx_reg - IW'(1)) : fidx_reg;
                                res_status_reg    <= wfa_pkg::ST_OK;
                                res_off_reg       <= '0;
                                split_reg         <= 1'b0;
                                up_reg            <= 1'b0;
                                k_reg             <= k;
                                sh_src_reg        <= IW'(CW'(tgt) + CW'(1) + CW'(k));
                                sh_cnt_reg        <= (k == 2'd0) ? '0
                                                     : (total_reg - CW'(tgt) - CW'(1)
                                                        - CW'(k));
                                wb_reg            <= tgt;
                                wb_data_reg.used  <= 1'b0;
                                wb_data_reg.bytes <= pf ? (prev_reg.bytes + merged + HDR16)
                                                     : merged;
                                total_reg         <= total_reg - CW'(k);
                                state_reg         <= S_SHIFT;
                            end
                        end
                    end

                    S_SHIFT:
                    begin
                        // Reads run one entry ahead of writes and move away from them.
                        wpv_reg <= sh_issue;
                        if (sh_issue)
                        begin
                            wdst_reg   <= up_reg ? (sh_src_reg + IW'(1))
                                          : (sh_src_reg - IW'(k_reg));
                            sh_src_reg <= up_reg ? (sh_src_reg - IW'(1))
                                          : (sh_src_reg + IW'(1));
                            sh_cnt_reg <= sh_cnt_reg - CW'(1);
                        end
                        if (!sh_issue && !wpv_reg)
                        begin
                            state_reg <= split_reg ? S_WR_A : S_WR_B;
                        end
                    end

                    S_WR_A:
                    begin
                        state_reg <= S_WR_B;
                    end

                    S_WR_B:
                    begin
                        state_reg <= S_DONE;
                    end

                    S_DONE:
                    begin
                        if (!out_valid_reg || rsp.ready)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= res_status_reg;
                            out_off_reg    <= res_off_reg;
                            state_reg      <= S_IDLE;
                        end
                    end

                    default:
                    begin
                        state_reg <= S_INIT;
                    end
                endcase
            end
        end
    end

endmodule

[src/wfa_ram.sv]
module wfa_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [wfa_pkg::IDX_W-1:0] waddr,
    input  wfa_pkg::entry_t           wdata,
    input  logic [wfa_pkg::IDX_W-1:0] raddr,
    output wfa_pkg::entry_t           rdata
);

    wfa_pkg::entry_t mem [wfa_pkg::MAX_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[bench/tb_top.sv]
module tb_top;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;

    wfa_req_if req ();
    wfa_rsp_if rsp ();

    worst_fit_arena_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    typedef struct packed {
        wfa_pkg::status_t status;
        logic [15:0]      offset;
    } grant_t;

    typedef struct packed {
        wfa_pkg::opcode_t op;
        logic [15:0]      bytes;
        logic [15:0]      offset;
        logic             has_exp;
        wfa_pkg::status_t exp_status;
        logic [15:0]      exp_offset;
    } row_t;

    // Predictor state.
    logic [15:0] mdl_arena;
    logic [15:0] mdl_bytes [wfa_pkg::MAX_BLOCKS];
    logic        mdl_used [wfa_pkg::MAX_BLOCKS];
    int          mdl_total;

    grant_t pending_grants [$];
    logic [15:0] live_offsets [$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic recv_hold = 1'b0;
    logic sending_done = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("worst_fit_arena_allocator test failed");
            $finish;
        end
    end

    function automatic void table_reset(input logic [15:0] arena);
        mdl_arena = arena;
        for (int j = 0; j < wfa_pkg::MAX_BLOCKS; j++)
        begin
            mdl_bytes[j] = 16'd0;
            mdl_used[j] = 1'b0;
        end
        mdl_bytes[0] = (arena > wfa_pkg::HEADER_BYTES)
                       ? 16'(arena - wfa_pkg::HEADER_BYTES) : 16'd0;
        mdl_total = 1;
    endfunction

    function automatic logic [15:0] payload_of(input int idx);
        int unsigned off;
        off = 0;
        for (int j = 0; j < idx; j++)
            off += wfa_pkg::HEADER_BYTES + mdl_bytes[j];
        return 16'(off + wfa_pkg::HEADER_BYTES);
    endfunction

    function automatic void drop_block(input int idx);
        for (int j = idx; j + 1 < mdl_total; j++)
        begin
            mdl_bytes[j] = mdl_bytes[j + 1];
            mdl_used[j] = mdl_used[j + 1];
        end
        mdl_total--;
        mdl_bytes[mdl_total] = 16'd0;
        mdl_used[mdl_total] = 1'b0;
    endfunction

    function automatic grant_t predict_grant(input wfa_pkg::opcode_t op,
                                             input logic [15:0] sz,
                                             input logic [15:0] target);
        grant_t g;
        int best;
        int unsigned bestv;
        int unsigned need;
        int unsigned off;
        bit found;
        g.status = wfa_pkg::ST_OK;
        g.offset = 16'd0;
        best = 0;
        bestv = 0;
        found = 0;
        if (op == wfa_pkg::OP_ALLOC)
        begin
            need = sz + wfa_pkg::HEADER_BYTES;
            if (sz > mdl_arena)
            begin
                g.status = wfa_pkg::ST_NO_FIT;
                return g;
            end
            for (int i = 0; i < mdl_total; i++)
                if (!mdl_used[i] && mdl_bytes[i] >= need && mdl_bytes[i] > bestv)
                begin
                    best = i;
                    bestv = mdl_bytes[i];
                    found = 1;
                end
            if (found)
            begin
                if (mdl_total >= wfa_pkg::MAX_BLOCKS)
                begin
                    g.status = wfa_pkg::ST_TABLE_FULL;
                    return g;
                end
                for (int j = mdl_total; j > best + 1; j--)
                begin
                    mdl_bytes[j] = mdl_bytes[j - 1];
                    mdl_used[j] = mdl_used[j - 1];
                end
                mdl_bytes[best + 1] = 16'(mdl_bytes[best] - need);
                mdl_used[best + 1] = 1'b0;
                mdl_total++;
                mdl_bytes[best] = sz;
                mdl_used[best] = 1'b1;
                g.offset = payload_of(best);
                return g;
            end
            for (int i = 0; i < mdl_total; i++)
                if (!mdl_used[i] && mdl_bytes[i] >= sz && mdl_bytes[i] < need
                    && mdl_bytes[i] > bestv)
                begin
                    best = i;
                    bestv = mdl_bytes[i];
                    found = 1;
                end
            if (!found)
            begin
                g.status = wfa_pkg::ST_NO_FIT;
                return g;
            end
            mdl_used[best] = 1'b1;
            g.offset = payload_of(best);
            return g;
        end
        off = wfa_pkg::HEADER_BYTES;
        for (int i = 0; i < mdl_total; i++)
        begin
            if (off == target)
            begin
                best = i;
                found = 1;
                break;
            end
            off += mdl_bytes[i] + wfa_pkg::HEADER_BYTES;
        end
        if (!found)
            g.status = wfa_pkg::ST_UNKNOWN;
        else if (!mdl_used[best])
            g.status = wfa_pkg::ST_ALREADY_FREE;
        else
        begin
            mdl_used[best] = 1'b0;
            if (best + 1 < mdl_total && !mdl_used[best + 1])
            begin
                mdl_bytes[best] = 16'(mdl_bytes[best] + mdl_bytes[best + 1]
                                      + wfa_pkg::HEADER_BYTES);
                drop_block(best + 1);
            end
            if (best > 0 && !mdl_used[best - 1])
            begin
                mdl_bytes[best - 1] = 16'(mdl_bytes[best - 1] + mdl_bytes[best]
                                          + wfa_pkg::HEADER_BYTES);
                drop_block(best);
            end
        end
        return g;
    endfunction

    // Send one request and queue its expected grant. Valid stays high after
    // the transfer until an idle cycle or a drain lowers it.
    task automatic send_request(input row_t r);
        grant_t g;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        g = predict_grant(r.op, r.bytes, r.offset);
        if (r.has_exp && (g.status != r.exp_status || g.offset != r.exp_offset))
        begin
            errors++;
            if (errors <= 10)
                $display("table row mismatch: typed %0d/%0d predicted %0d/%0d",
                         r.exp_status, r.exp_offset, g.status, g.offset);
        end
        if (r.op == wfa_pkg::OP_ALLOC && g.status == wfa_pkg::ST_OK)
            live_offsets.push_back(g.offset);
        pending_grants.push_back(g);
        req.valid <= 1'b1;
        req.opcode <= r.op;
        req.request_bytes <= r.bytes;
        req.release_offset <= r.offset;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (2 * wfa_pkg::MAX_BLOCKS + 20)
            @(posedge clk);
    endtask

    task automatic write_arena(input logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        table_reset(v);
        live_offsets.delete();
        @(posedge clk);
    endtask

    function automatic row_t random_row();
        row_t r;
        int k;
        r = '0;
        r.bytes = 16'($urandom);
        r.offset = 16'($urandom);
        k = $urandom_range(99);
        if (k < 45)
        begin
            r.op = wfa_pkg::OP_ALLOC;
            r.bytes = (k < 40) ? 16'($urandom_range(0, 200)) : 16'($urandom);
        end
        else
        begin
            r.op = wfa_pkg::OP_FREE;
            if (k < 85 && live_offsets.size() != 0)
            begin
                k = $urandom_range(live_offsets.size() - 1);
                r.offset = live_offsets[k];
                // Keep some freed offsets around so double frees happen.
                if ($urandom_range(3) != 0)
                    live_offsets.delete(k);
            end
        end
        return r;
    endfunction

    // Receiver side with mismatch checking.
    always @(posedge clk)
    begin
        grant_t exp_g;
        if (rst_n)
            rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        if (rsp.valid && rsp.ready)
        begin
            if (pending_grants.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer: status %0d offset %0d",
                             rsp.status, rsp.payload_offset);
            end
            else
            begin
                exp_g = pending_grants.pop_front();
                if (rsp.status != exp_g.status || rsp.payload_offset != exp_g.offset)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %0d/%0d actual %0d/%0d",
                                 exp_g.status, exp_g.offset, rsp.status,
                                 rsp.payload_offset);
                end
            end
        end
    end

    // Long receiver hold-off, counted here, while requests keep coming.
    initial
    begin
        wait (sending_done === 1'b0 && cycles > 3000);
        recv_hold <= 1'b1;
        repeat (400)
            @(posedge clk);
        recv_hold <= 1'b0;
    end

    row_t dir_rows [$];

    initial
    begin
        req.valid = 1'b0;
        req.opcode = wfa_pkg::OP_ALLOC;
        req.request_bytes = 16'd0;
        req.release_offset = 16'd0;
        rsp.ready = 1'b0;
        table_reset(16'(wfa_pkg::ARENA_RESET));
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (3)
            @(posedge clk);

        // Directed rows; typed expectations only where obvious.
        dir_rows = '{
            '{wfa_pkg::OP_FREE, 16'd0, 16'd16, 1'b1, wfa_pkg::ST_ALREADY_FREE, 16'd0},
            '{wfa_pkg::OP_FREE, 16'd0, 16'd0, 1'b1, wfa_pkg::ST_UNKNOWN, 16'd0},
            '{wfa_pkg::OP_FREE, 16'd0, 16'hFFFF, 1'b1, wfa_pkg::ST_UNKNOWN, 16'd0},
            '{wfa_pkg::OP_ALLOC, 16'hFFFF, 16'd0, 1'b1, wfa_pkg::ST_NO_FIT, 16'd0},
            '{wfa_pkg::OP_ALLOC, 16'd4097, 16'd0, 1'b1, wfa_pkg::ST_NO_FIT, 16'd0},
            '{wfa_pkg::OP_ALLOC, 16'd4096, 16'd0, 1'b1, wfa_pkg::ST_NO_FIT, 16'd0},
            '{wfa_pkg::OP_ALLOC, 16'd100, 16'd0, 1'b1, wfa_pkg::ST_OK, 16'd16},
            '{wfa_pkg::OP_ALLOC, 16'd0, 16'd0, 1'b0, wfa_pkg::ST_OK, 16'd0},
            '{wfa_pkg::OP_ALLOC, 16'd200, 16'd0, 1'b0, wfa_pkg::ST_OK, 16'd0},
            '{wfa_pkg::OP_FREE, 16'd0, 16'd132, 1'b0, wfa_pkg::ST_OK, 16'd0},
            '{wfa_pkg::OP_FREE, 16'd0, 16'd132, 1'b1, wfa_pkg::ST_ALREADY_FREE, 16'd0},
            '{wfa_pkg::OP_FREE, 16'd0, 16'd16, 1'b0, wfa_pkg::ST_OK, 16'd0},
            '{wfa_pkg::OP_ALLOC, 16'd3000, 16'd0, 1'b0, wfa_pkg::ST_OK, 16'd0},
            '{wfa_pkg::OP_ALLOC, 16'd1000, 16'd0, 1'b0, wfa_pkg::ST_OK, 16'd0}
        };
        foreach (dir_rows[i])
            send_request(dir_rows[i]);

        // Tiny arenas: exactly one header, and one header plus a bit; then the largest arena.
        write_arena(16'd16);
        send_request('{wfa_pkg::OP_ALLOC, 16'd0, 16'd0, 1'b1, wfa_pkg::ST_NO_FIT, 16'd0});
        send_request('{wfa_pkg::OP_ALLOC, 16'd17, 16'd0, 1'b1, wfa_pkg::ST_NO_FIT, 16'd0});
        write_arena(16'd40);
        send_request('{wfa_pkg::OP_ALLOC, 16'd20, 16'd0, 1'b0, wfa_pkg::ST_OK, 16'd0});
        send_request('{wfa_pkg::OP_ALLOC, 16'd8, 16'd0, 1'b0, wfa_pkg::ST_OK, 16'd0});
        write_arena(16'hFFFF);
        send_request('{wfa_pkg::OP_ALLOC, 16'hFFFF, 16'd0, 1'b0, wfa_pkg::ST_OK, 16'd0});
        send_request('{wfa_pkg::OP_ALLOC, 16'hFFEF, 16'd0, 1'b0, wfa_pkg::ST_OK, 16'd0});
        // Fill the table with tiny splits to hit table_full.
        write_arena(16'd4096);
        for (int i = 0; i < wfa_pkg::MAX_BLOCKS + 2; i++)
            send_request('{wfa_pkg::OP_ALLOC, 16'd1, 16'd0, 1'b0, wfa_pkg::ST_OK, 16'd0});

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 57 : 0;
            recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 7 : 0;
            write_arena((phase == 0) ? 16'd1024 : (phase == 1) ? 16'd600 : 16'd8192);
            for (int n = 0; n < 155; n++)
            begin
                send_request(random_row());
                if (n == 90)
                    drain();
            end
        end
        sending_done <= 1'b1;
        drain();
        if (errors == 0)
            $display("worst_fit_arena_allocator test passed");
        else
            $display("worst_fit_arena_allocator test failed");
        $finish;
    end
endmodule
